// ===== src/vertex_weld_first_match_defines.svh =====
// Assertion helpers, included by vwfm_seq.sv.
`ifndef VERTEX_WELD_FIRST_MATCH_DEFINES_SVH
`define VERTEX_WELD_FIRST_MATCH_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define VWFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define VWFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/vwfm_pkg.sv =====
package vwfm_pkg;

  localparam int MaxVertices = 4096;
  localparam int IdxW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int IdxFieldW   = 12;
  localparam int CoordW      = 24;
  localparam int ThreshW     = 48;
  localparam int MagW        = CoordW + 1;
  localparam int SqW         = 2 * MagW;
  localparam int SumW        = SqW + 2;
  localparam int PaddrW      = 3;
  localparam int PdataW      = 64;

  localparam logic [PaddrW-1:0]  ThreshAddr  = '0;
  localparam logic [ThreshW-1:0] ThreshReset = ThreshW'(1);

  typedef struct packed {
    logic                     start_mesh;
    logic signed [CoordW-1:0] x_pos;
    logic signed [CoordW-1:0] y_pos;
    logic signed [CoordW-1:0] z_pos;
  } in_t;

  typedef struct packed {
    logic [IdxFieldW-1:0] vertex_number;
    logic [IdxFieldW-1:0] canonical_index;
    logic                 is_duplicate;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    point_t          pt;
  } dist_req_t;

  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [IdxW-1:0] idx;
    logic            busy;
  } dist_rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StEmit
  } st_e;

endpackage

// ===== src/vwfm_ram.sv =====
module vwfm_ram #(
  parameter int Width = 72,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/vwfm_dist.sv =====
module vwfm_dist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      flush_i,
  input  vwfm_pkg::dist_req_t       req_i,
  input  vwfm_pkg::point_t          query_i,
  input  logic [vwfm_pkg::ThreshW-1:0] thresh_i,
  output vwfm_pkg::dist_rsp_t       rsp_o
);
  import vwfm_pkg::*;

  // Four stages: magnitudes, squares, sum, compare.
  logic [3:0]      v_q, v_d;
  logic [IdxW-1:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic [MagW-1:0] mx_q, my_q, mz_q;
  logic [SqW-1:0]  sx_q, sy_q, sz_q;
  logic [SumW-1:0] sum_q;
  logic            hit_q;

  logic signed [MagW-1:0] dx, dy, dz;

  always_comb begin
    dx = MagW'(query_i.x) - MagW'(req_i.pt.x);
    dy = MagW'(query_i.y) - MagW'(req_i.pt.y);
    dz = MagW'(query_i.z) - MagW'(req_i.pt.z);
    v_d = flush_i ? 4'b0000 : {v_q[2:0], req_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= req_i.idx;
    mx_q   <= dx[MagW-1] ? MagW'(-dx) : MagW'(dx);
    my_q   <= dy[MagW-1] ? MagW'(-dy) : MagW'(dy);
    mz_q   <= dz[MagW-1] ? MagW'(-dz) : MagW'(dz);
    idx2_q <= idx1_q;
    sx_q   <= mx_q * mx_q;
    sy_q   <= my_q * my_q;
    sz_q   <= mz_q * mz_q;
    idx3_q <= idx2_q;
    sum_q  <= SumW'(sx_q) + SumW'(sy_q) + SumW'(sz_q);
    idx4_q <= idx3_q;
    hit_q  <= sum_q < SumW'(thresh_i);
  end

  assign rsp_o.valid = v_q[3];
  assign rsp_o.hit   = hit_q;
  assign rsp_o.idx   = idx4_q;
  assign rsp_o.busy  = |v_q;

endmodule

// ===== src/vwfm_seq.sv =====
module vwfm_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vwfm_pkg::in_t                in_data_i,
  input  logic [vwfm_pkg::ThreshW-1:0] thresh_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output vwfm_pkg::out_t               res_o
);
  import vwfm_pkg::*;
  `include "vertex_weld_first_match_defines.svh"

  st_e             state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic [IdxW-1:0] own_q, own_d;
  logic [IdxW-1:0] canon_q, canon_d;
  logic            dup_q, dup_d;
  logic            ovf_q, ovf_d;
  logic            rd_v_q, rd_v_d;
  logic [IdxW-1:0] rd_idx_q;
  point_t          query_q, query_d;

  logic            ram_we, ram_re, flush;
  logic [IdxW-1:0] ram_addr;
  point_t          ram_rdata;
  logic [CntW-1:0] cnt_eff;
  dist_req_t       req;
  dist_rsp_t       rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      iss_q   <= '0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      iss_q   <= iss_d;
      rd_v_q  <= rd_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q    <= own_d;
    canon_q  <= canon_d;
    dup_q    <= dup_d;
    ovf_q    <= ovf_d;
    query_q  <= query_d;
    rd_idx_q <= ram_addr;
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    iss_d    = iss_q;
    own_d    = own_q;
    canon_d  = canon_q;
    dup_d    = dup_q;
    ovf_d    = ovf_q;
    query_d  = query_q;
    rd_v_d   = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = iss_q[IdxW-1:0];
    flush    = 1'b0;
    cnt_eff  = in_data_i.start_mesh ? '0 : count_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          count_d   = cnt_eff;
          query_d.x = in_data_i.x_pos;
          query_d.y = in_data_i.y_pos;
          query_d.z = in_data_i.z_pos;
          iss_d     = '0;
          dup_d     = 1'b0;
          if (cnt_eff >= CntW'(MaxVertices)) begin
            // Full store: no compare, no write, all indexes zero.
            ovf_d   = 1'b1;
            own_d   = '0;
            canon_d = '0;
            state_d = StEmit;
          end else begin
            ovf_d   = 1'b0;
            own_d   = cnt_eff[IdxW-1:0];
            canon_d = cnt_eff[IdxW-1:0];
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (rsp.valid && rsp.hit) begin
          // Results come back in address order, so the first hit is the answer.
          canon_d = rsp.idx;
          dup_d   = 1'b1;
          flush   = 1'b1;
          state_d = StWrite;
        end else if (iss_q < CntW'(own_q)) begin
          ram_re = 1'b1;
          rd_v_d = 1'b1;
          iss_d  = iss_q + CntW'(1);
        end else if (!rd_v_q && !rsp.busy) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        ram_we   = 1'b1;
        ram_addr = own_q;
        count_d  = CntW'(own_q) + CntW'(1);
        state_d  = StEmit;
      end
      StEmit: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign res_o.vertex_number   = IdxFieldW'(own_q);
  assign res_o.canonical_index = IdxFieldW'(canon_q);
  assign res_o.is_duplicate    = dup_q;
  assign res_o.overflow        = ovf_q;

  assign req.valid = rd_v_q && !flush;
  assign req.idx   = rd_idx_q;
  assign req.pt    = ram_rdata;

  vwfm_ram #(
    .Width($bits(point_t)),
    .Depth(MaxVertices)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(query_q),
    .rdata_o(ram_rdata)
  );

  vwfm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (flush),
    .req_i   (req),
    .query_i (query_q),
    .thresh_i(thresh_i),
    .rsp_o   (rsp)
  );

  `VWFM_ASSERT(a_idle_drained, (state_q == StIdle) |-> (!rd_v_q && !rsp.busy), "reads in flight while idle")
  `VWFM_ASSERT(a_read_in_range, ram_re |-> (iss_q < CntW'(own_q)), "read beyond stored vertices")
  `VWFM_ASSERT(a_hit_before_own, rsp.valid |-> (rsp.idx < own_q), "match index not below own index")
  `VWFM_ASSERT(a_write_then_emit, ram_we |=> (state_q == StEmit && count_q == CntW'(own_q) + CntW'(1)), "store write not followed by result")
  `VWFM_ASSERT(a_count_bound, count_q <= CntW'(MaxVertices), "vertex count above capacity")
  `VWFM_ASSERT_ALWAYS(a_rw_exclusive, !(ram_we && ram_re), "store read and write in one cycle")

endmodule

// ===== src/vertex_weld_first_match.sv =====
// Vertex welder: one input beat carries a vertex (start_mesh, x/y/z, signed
// 24-bit with 8 fraction bits). One output beat per input reports the
// vertex's own index, the first earlier vertex of the mesh whose squared
// distance is strictly below weld_threshold_sq, and duplicate/overflow flags.
// The threshold is written over the APB port at address 0 (64-bit data, low
// 48 bits used) and may only change while the block is idle.
// One vertex is in work at a time. Each stored vertex is read from the point
// memory once per cycle and fed to a four-stage distance pipeline. The scan
// stops at the first match; with no match it covers every stored vertex of
// the mesh, at most 4095. A vertex arriving at a full store is answered
// without a scan or a write.
// Reset clears the vertex count and sets the threshold to 1; point memory
// contents are not cleared and need no clearing pass.
// The result waits in an output register, so the next vertex is accepted
// while the receiver stalls; work stops only if a second result is ready
// before the first has been taken.
module vertex_weld_first_match (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vwfm_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vwfm_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vwfm_pkg::PaddrW-1:0]  paddr,
  input  logic [vwfm_pkg::PdataW-1:0]  pwdata,
  output logic [vwfm_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import vwfm_pkg::*;

  logic [ThreshW-1:0] thresh_q, thresh_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_data_q, out_data_d;
  logic               res_valid, res_ready;
  out_t               res;

  assign pready = 1'b1;
  assign prdata = (paddr == ThreshAddr) ? PdataW'(thresh_q) : '0;

  always_comb begin
    thresh_d = thresh_q;
    if (psel && penable && pwrite && pready && paddr == ThreshAddr) begin
      thresh_d = pwdata[ThreshW-1:0];
    end
  end

  // The output register is free when empty or when its beat leaves this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= ThreshReset;
      out_valid_q <= 1'b0;
    end else begin
      thresh_q    <= thresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  vwfm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .thresh_i   (thresh_q),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

endmodule

// ===== dv/weld_checker.sv =====
`timescale 1ns / 1ps

// Watches both vertex channels and the register port of the welder. It keeps
// its own copy of the mesh and the threshold, predicts the result of every
// accepted vertex, and compares each result beat with the oldest prediction.
module weld_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  vwfm_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  vwfm_pkg::out_t                out_data_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [vwfm_pkg::PaddrW-1:0]   paddr_i,
  input  logic [vwfm_pkg::PdataW-1:0]   pwdata_i,
  input  logic [vwfm_pkg::PdataW-1:0]   prdata_i,
  output int                            errors_o,
  output int                            pending_o
);
  import vwfm_pkg::*;

  point_t             mesh_points [MaxVertices];
  int unsigned        mesh_count;
  logic [ThreshW-1:0] weld_limit;
  out_t               expected_welds [$];
  out_t               oldest_weld;
  int                 errors;

  assign errors_o = errors;

  function automatic longint unsigned axis_sq(logic signed [CoordW-1:0] a,
                                              logic signed [CoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  // Scans the mesh in arrival order; the first point strictly inside the
  // threshold wins. A full store is neither scanned nor written.
  function automatic out_t predict_weld(in_t v);
    out_t              r;
    point_t            p;
    longint unsigned   sq_dist;
    int unsigned       i;
    r = '0;
    if (v.start_mesh) mesh_count = 0;
    p.x = v.x_pos;
    p.y = v.y_pos;
    p.z = v.z_pos;
    if (mesh_count >= MaxVertices) begin
      r.overflow = 1'b1;
      return r;
    end
    r.vertex_number   = IdxFieldW'(mesh_count);
    r.canonical_index = IdxFieldW'(mesh_count);
    for (i = 0; i < mesh_count && !r.is_duplicate; i++) begin
      sq_dist = axis_sq(p.x, mesh_points[i].x) + axis_sq(p.y, mesh_points[i].y)
              + axis_sq(p.z, mesh_points[i].z);
      if (sq_dist < 64'(weld_limit)) begin
        r.canonical_index = IdxFieldW'(i);
        r.is_duplicate    = 1'b1;
      end
    end
    mesh_points[mesh_count] = p;
    mesh_count++;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mesh_count = 0;
      weld_limit = ThreshReset;
      expected_welds.delete();
      errors    <= 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i == ThreshAddr) weld_limit = pwdata_i[ThreshW-1:0];
        end else if (paddr_i == ThreshAddr && prdata_i !== PdataW'(weld_limit)) begin
          $display("%0t: threshold readback mismatch, expected %0h, actual %0h",
                   $time, weld_limit, prdata_i);
          errors++;
        end
      end
      // Results are retired before the new vertex is predicted, since a
      // vertex can never be answered on the edge that accepts it.
      if (out_valid_i && out_ready_i) begin
        if (expected_welds.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0h",
                   $time, out_data_i);
          errors++;
        end else begin
          oldest_weld = expected_welds.pop_front();
          check_field("vertex_number", oldest_weld.vertex_number,
                      out_data_i.vertex_number);
          check_field("canonical_index", oldest_weld.canonical_index,
                      out_data_i.canonical_index);
          check_field("is_duplicate", oldest_weld.is_duplicate, out_data_i.is_duplicate);
          check_field("overflow", oldest_weld.overflow, out_data_i.overflow);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_welds = {expected_welds, predict_weld(in_data_i)};
      end
      pending_o <= expected_welds.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import vwfm_pkg::*;

  localparam int CoordMax = 8388607;
  localparam int CoordMin = -8388608;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b1;
  out_t                out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PaddrW-1:0]   paddr     = '0;
  logic [PdataW-1:0]   pwdata    = '0;
  logic [PdataW-1:0]   prdata;
  logic                pready;

  int                  weld_errors;
  int                  weld_pending;
  bit                  no_idle = 1'b0;
  point_t              mesh_pool [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_weld_first_match dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  weld_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .errors_o    (weld_errors),
    .pending_o   (weld_pending)
  );

  // Mostly back to back, sometimes a short pause, rarely a long one; no pause when no_idle is set.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic point_t make_point(int x, int y, int z);
    point_t p;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.z = CoordW'(z);
    return p;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return CoordW'(CoordMin);
      1:       return CoordW'(CoordMax);
      2:       return '0;
      3:       return '1;
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic point_t jitter_point(point_t p, int spread);
    point_t q;
    int     off;
    off = int'($urandom_range(0, 2 * spread)) - spread;
    q.x = CoordW'(int'(p.x) + off);
    off = int'($urandom_range(0, 2 * spread)) - spread;
    q.y = CoordW'(int'(p.y) + off);
    off = int'($urandom_range(0, 2 * spread)) - spread;
    q.z = CoordW'(int'(p.z) + off);
    return q;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the beat with
  // valid still high, so a following beat can go out without a gap.
  task automatic send_vertex(bit start, point_t p);
    int  gap;
    in_t beat;
    gap = idle_len();
    beat.start_mesh = start;
    beat.x_pos = p.x;
    beat.y_pos = p.y;
    beat.z_pos = p.z;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (start) mesh_pool.delete();
    mesh_pool = {mesh_pool, p};
    if (mesh_pool.size() > 48) void'(mesh_pool.pop_front());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (weld_pending != 0);
  endtask

  // A write followed directly by a readback of the threshold register.
  task automatic write_reg_and_readback(logic [PaddrW-1:0] waddr,
                                        logic [PdataW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= waddr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ThreshAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    forever begin
      int stall;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    point_t            p;
    bit                start;
    int                r;
    logic [PdataW-1:0] limit;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset threshold of one: only exact copies weld.
    send_vertex(1'b1, make_point(0, 0, 0));
    send_vertex(1'b0, make_point(0, 0, 0));
    send_vertex(1'b0, make_point(1, 0, 0));
    send_vertex(1'b0, make_point(1, 0, 0));
    send_vertex(1'b0, make_point(CoordMax, CoordMax, CoordMax));
    send_vertex(1'b0, make_point(CoordMin, CoordMin, CoordMin));
    send_vertex(1'b0, make_point(CoordMin, CoordMin, CoordMin));
    wait_idle();

    // A write to an address with no register must leave the threshold alone.
    write_reg_and_readback(PaddrW'($urandom_range(1, 7)), '0);
    write_reg_and_readback(ThreshAddr, '1);
    send_vertex(1'b1, make_point(CoordMax, CoordMax, CoordMax));
    send_vertex(1'b0, make_point(CoordMin, CoordMin, CoordMin));
    send_vertex(1'b0, make_point(0, 0, 0));
    send_vertex(1'b0, make_point(-1, -1, -1));
    send_vertex(1'b1, make_point(0, 0, 0));
    wait_idle();

    // Distance of exactly one unit is not below a threshold of one unit.
    write_reg_and_readback(ThreshAddr, PdataW'(1 << 16));
    send_vertex(1'b1, make_point(0, 0, 0));
    send_vertex(1'b0, make_point(256, 0, 0));
    send_vertex(1'b0, make_point(255, 0, 0));
    send_vertex(1'b0, make_point(0, -181, -181));
    wait_idle();

    write_reg_and_readback(ThreshAddr, '0);
    send_vertex(1'b1, make_point(5, 5, 5));
    send_vertex(1'b0, make_point(5, 5, 5));
    send_vertex(1'b0, make_point(5, 5, 5));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      case (ph % 6)
        0:       limit = PdataW'(1 << 16);
        1:       limit = '0;
        2:       limit = {$urandom, $urandom};
        3:       limit = '1;
        4:       limit = PdataW'($urandom_range(1, 1 << 20));
        default: limit = {$urandom, 32'h1};
      endcase
      write_reg_and_readback(ThreshAddr, limit);
      for (int k = 0; k < 15; k++) begin
        start = (k == 0 && ph % 2 == 0) || $urandom_range(0, 11) == 0;
        r = $urandom_range(0, 9);
        if (mesh_pool.size() == 0 || r < 2) begin
          p = make_point(rand_coord(), rand_coord(), rand_coord());
        end else if (r < 4) begin
          p = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
        end else begin
          case ($urandom_range(0, 3))
            0:       p = jitter_point(mesh_pool[$urandom_range(0, mesh_pool.size() - 1)], 16);
            1:       p = jitter_point(mesh_pool[$urandom_range(0, mesh_pool.size() - 1)], 255);
            2:       p = jitter_point(mesh_pool[$urandom_range(0, mesh_pool.size() - 1)], 256);
            default: p = jitter_point(mesh_pool[$urandom_range(0, mesh_pool.size() - 1)], 1024);
          endcase
        end
        send_vertex(start, p);
      end
      wait_idle();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    if (weld_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/vwfm_pkg.sv
src/vwfm_ram.sv
src/vwfm_dist.sv
src/vwfm_seq.sv
src/vertex_weld_first_match.sv
dv/weld_checker.sv
dv/testbench.sv
